FILE: sv/kth_smallest_select_assert.svh
// Assertion macros shared by the kth-smallest select RTL.
`ifndef KTH_SMALLEST_SELECT_ASSERT_SVH
`define KTH_SMALLEST_SELECT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define KSS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kss assertion failed");
// Next-cycle implication.
`define KSS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kss assertion failed");
`else
`define KSS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define KSS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: sv/kss_pkg.sv
// Shared constants for the kth-smallest select block.
package kss_pkg;

  localparam int VALUE_W       = 32;
  localparam int RANK_W        = 11;
  localparam int ERR_W         = 2;
  localparam int DEPTH_DEFAULT = 1024;

  localparam logic [RANK_W-1:0] RANK_RESET = 11'd1;

  // result error codes
  localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANK     = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

endpackage

FILE: sv/kss_if.sv
// Valid/ready channel interfaces: input values, results and rank writes.
interface kss_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [kss_pkg::VALUE_W-1:0] value;
  logic                              last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface kss_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [kss_pkg::VALUE_W-1:0] selected;
  logic [kss_pkg::ERR_W-1:0]          error;

  modport source (output valid, output selected, output error, input ready);
  modport sink   (input valid, input selected, input error, output ready);
endinterface

interface kss_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [kss_pkg::RANK_W-1:0]  rank;

  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);
endinterface

FILE: sv/kss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/kss_rank_unit.sv
// Shared compare unit: counts stored values below and up to a candidate.
module kss_rank_unit #(
  parameter int CNT_W = 11
) (
  input  logic                               clk,
  input  logic                               clear,
  input  logic                               sample_valid,
  input  logic signed [kss_pkg::VALUE_W-1:0] sample,
  input  logic signed [kss_pkg::VALUE_W-1:0] cand,
  output logic [CNT_W-1:0]                   below,
  output logic [CNT_W-1:0]                   upto
);

  logic is_lt;
  logic is_le;

  // one signed less-than and one less-or-equal compare per streamed value
  assign is_lt = sample < cand;
  assign is_le = sample <= cand;

  always_ff @(posedge clk) begin
    if (clear) begin
      below <= '0;
      upto  <= '0;
    end else if (sample_valid) begin
      below <= below + CNT_W'(is_lt);
      upto  <= upto + CNT_W'(is_le);
    end
  end

endmodule

FILE: sv/kth_smallest_select.sv
// Kth-smallest select: loads a set of signed values and returns its rank-th smallest.
// Values stream in at one beat per cycle while loading; the beat with last_item
// closes the set. Selection then tests stored values one by one as candidates:
// for each, one compare unit sweeps the whole store through the single RAM read
// port, counting values below and up to the candidate; the search ends at the first
// candidate that holds the rank, and no input beat is taken during it. A rank of
// zero or above the set size n gives error 1, a set that overran the store gives
// error 2; both return selected 0. The result sits in an output register, so
// loading of the next set goes on while it waits to be taken. Rank writes are
// accepted at any time, meant while idle.
module kth_smallest_select #(
  parameter int DEPTH = kss_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  kss_in_if.sink    items,
  kss_out_if.source results,
  kss_cfg_if.sink   cfg
);

`include "kth_smallest_select_assert.svh"

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > kss_pkg::RANK_W) ? CW : kss_pkg::RANK_W;
  localparam int VW   = kss_pkg::VALUE_W;

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_CLOSE = 7'b0000010,
    S_CAND  = 7'b0000100,
    S_LATCH = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                        state;
  logic [CW-1:0]                 count;
  logic                          ovf;
  logic [kss_pkg::RANK_W-1:0]    rank;
  logic [AW-1:0]                 cand;
  logic [CW-1:0]                 scan;
  logic signed [VW-1:0]          cand_val;
  logic signed [VW-1:0]          pend_sel;
  logic [kss_pkg::ERR_W-1:0]     pend_err;
  logic                          res_valid;
  logic signed [VW-1:0]          res_sel;
  logic [kss_pkg::ERR_W-1:0]     res_err;

  logic                          item_acc;
  logic                          store_write;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic signed [VW-1:0]          ram_rdata;
  logic [CW-1:0]                 below;
  logic [CW-1:0]                 upto;
  logic                          rank_bad;
  logic                          found;
  logic                          cand_last;
  logic                          out_free;

  // handshakes
  assign items.ready = (state == S_LOAD);
  assign cfg.ready   = 1'b1;
  assign item_acc    = items.valid && items.ready;
  assign store_write = item_acc && (count < CW'(DEPTH));
  assign out_free    = !res_valid || results.ready;

  assign results.valid    = res_valid;
  assign results.selected = res_sel;
  assign results.error    = res_err;

  // rank checks against the loaded set and the running counts
  assign rank_bad  = (rank == '0) || (CMPW'(rank) > CMPW'(count));
  assign found     = (CMPW'(below) < CMPW'(rank)) && (CMPW'(rank) <= CMPW'(upto));
  assign cand_last = (CW'(cand) + CW'(1)) >= count;

  // store read address: candidate fetch, then the sweep
  always_comb begin
    ram_raddr = cand;
    ram_re    = 1'b0;
    case (state)
      S_CAND: begin
        ram_re = 1'b1;
      end
      S_LATCH: begin
        ram_raddr = '0;
        ram_re    = 1'b1;
      end
      S_SCAN: begin
        ram_raddr = scan[AW-1:0];
        ram_re    = (scan < count);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  kss_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_write),
    .waddr (count[AW-1:0]),
    .wdata (items.value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kss_rank_unit #(
    .CNT_W (CW)
  ) u_rank (
    .clk          (clk),
    .clear        (state == S_LATCH),
    .sample_valid (state == S_SCAN),
    .sample       (ram_rdata),
    .cand         (cand_val),
    .below        (below),
    .upto         (upto)
  );

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      rank      <= kss_pkg::RANK_RESET;
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        rank <= cfg.rank;
      end
      // a new result takes the output register as the old one leaves
      if (state == S_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (item_acc) begin
            if (store_write) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (items.last_item) begin
              state <= S_CLOSE;
            end
          end
        end
        S_CLOSE: begin
          state <= (ovf || rank_bad) ? S_DONE : S_CAND;
        end
        S_CAND: begin
          state <= S_LATCH;
        end
        S_LATCH: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (scan == count) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= (found || cand_last) ? S_DONE : S_CAND;
        end
        S_DONE: begin
          if (out_free) begin
            count     <= '0;
            ovf       <= 1'b0;
            state     <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_CLOSE: begin
        cand     <= '0;
        pend_sel <= '0;
        if (ovf) begin
          pend_err <= kss_pkg::ERR_OVERFLOW;
        end else if (rank_bad) begin
          pend_err <= kss_pkg::ERR_RANK;
        end else begin
          pend_err <= kss_pkg::ERR_OK;
        end
      end
      S_LATCH: begin
        cand_val <= ram_rdata;
        scan     <= CW'(1);
      end
      S_SCAN: begin
        if (scan != count) begin
          scan <= scan + CW'(1);
        end
      end
      S_CHECK: begin
        if (found) begin
          pend_sel <= cand_val;
        end else begin
          cand <= cand + AW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_sel <= pend_sel;
          res_err <= pend_err;
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  `KSS_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `KSS_ASSERT_IMP(a_err_zero, clk, rst, results.valid && results.error != kss_pkg::ERR_OK,
                  results.selected == '0)
  `KSS_ASSERT_IMP(a_scan_bound, clk, rst, state == S_SCAN, scan <= count && scan != '0)
  `KSS_ASSERT_NXT(a_close, clk, rst, item_acc && items.last_item, state == S_CLOSE)
  `KSS_ASSERT_IMP(a_cand_bound, clk, rst, state == S_CHECK, CW'(cand) < count)

endmodule
